// ===== rtl/core/scpwm_pkg.sv =====
// shared constants and types for the sorted compare led pwm core
package scpwm_pkg;

   localparam int SLOTS   = 8;
   localparam int SLOT_W  = 3;
   localparam int WALK_W  = 4;
   localparam int LEVEL_W = 8;
   localparam int PIN_W   = 5;
   localparam int PORT_W  = 32;

   localparam logic [LEVEL_W-1:0] UNUSED_LEVEL     = 8'hFF;
   localparam logic [LEVEL_W-1:0] PERIOD_TOP_RESET = 8'hFF;
   localparam logic [PORT_W-1:0]  CLEAR_MASK_RESET = 32'h8803_8300;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_COMMIT = 2'd2;

   localparam logic CSR_PERIOD_TOP = 1'b0;
   localparam logic CSR_CLEAR_MASK = 1'b1;

   typedef logic [SLOTS-1:0][LEVEL_W-1:0] level_arr_type;
   typedef logic [SLOTS-1:0][PIN_W-1:0]   pin_arr_type;

   typedef struct packed {
      logic               hit;
      logic               first_clear;
      logic [PORT_W-1:0]  set_mask;
      logic [WALK_W-1:0]  walk_next;
   } match_type;

endpackage

// ===== rtl/core/scpwm_table.sv =====
// shadow and active slot tables with commit at period wrap
module scpwm_table (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   write_en,
   input  logic [2:0]             write_slot,
   input  logic [7:0]             write_level,
   input  logic [4:0]             write_pin,
   input  logic                   commit_req,
   input  logic                   wrap,
   output scpwm_pkg::level_arr_type eff_level,
   output scpwm_pkg::pin_arr_type   eff_pin,
   output logic [3:0]             eff_valid
);
   import scpwm_pkg::*;

   level_arr_type     shadow_level_ff, shadow_level_in;
   pin_arr_type       shadow_pin_ff, shadow_pin_in;
   level_arr_type     active_level_ff;
   pin_arr_type       active_pin_ff;
   logic [WALK_W-1:0] valid_ff;
   logic              pending_ff, pending_in;
   logic [WALK_W-1:0] shadow_count;
   logic              load;

   always_comb begin
      shadow_count = '0;
      for (int j = 0; j < SLOTS; j++) begin
         if (shadow_level_ff[j] != UNUSED_LEVEL) begin
            shadow_count = shadow_count + WALK_W'(1);
         end
      end
   end

   assign load      = wrap && pending_ff;
   assign eff_level = load ? shadow_level_ff : active_level_ff;
   assign eff_pin   = load ? shadow_pin_ff : active_pin_ff;
   assign eff_valid = load ? shadow_count : valid_ff;

   always_comb begin
      shadow_level_in = shadow_level_ff;
      shadow_pin_in   = shadow_pin_ff;
      if (write_en) begin
         shadow_level_in[write_slot] = write_level;
         shadow_pin_in[write_slot]   = write_pin;
      end
      pending_in = load ? 1'b0 : pending_ff;
      if (commit_req) begin
         pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SLOTS; j++) begin
            shadow_level_ff[j] <= UNUSED_LEVEL;
            shadow_pin_ff[j]   <= '0;
            active_level_ff[j] <= UNUSED_LEVEL;
            active_pin_ff[j]   <= '0;
         end
         valid_ff   <= '0;
         pending_ff <= 1'b0;
      end else begin
         shadow_level_ff <= shadow_level_in;
         shadow_pin_ff   <= shadow_pin_in;
         pending_ff      <= pending_in;
         if (load) begin
            active_level_ff <= shadow_level_ff;
            active_pin_ff   <= shadow_pin_ff;
            valid_ff        <= shadow_count;
         end
      end
   end

endmodule

// ===== rtl/core/scpwm_match.sv =====
// compare of the pointed slot and the run of equal levels behind it
module scpwm_match (
   input  scpwm_pkg::level_arr_type eff_level,
   input  scpwm_pkg::pin_arr_type   eff_pin,
   input  logic [3:0]               eff_valid,
   input  logic [3:0]               walk,
   input  logic [7:0]               count,
   input  logic                     first_pending,
   output scpwm_pkg::match_type     result
);
   import scpwm_pkg::*;

   logic [LEVEL_W-1:0] lvl;
   logic               start;
   logic               consume;
   logic [SLOTS-1:0]   in_run;
   logic [WALK_W-1:0]  run_len;
   logic [PORT_W-1:0]  mask;

   assign lvl     = eff_level[walk[SLOT_W-1:0]];
   assign start   = (walk < eff_valid) && (lvl != UNUSED_LEVEL) && (lvl == count);
   assign consume = start && !first_pending;

   // run starts at the pointed slot and continues while levels stay equal
   always_comb begin
      in_run  = '0;
      run_len = '0;
      mask    = '0;
      for (int j = 0; j < SLOTS; j++) begin
         if (walk == WALK_W'(j)) begin
            in_run[j] = start;
         end else if (j > 0) begin
            in_run[j] = in_run[j-1] && (eff_level[j] == lvl) && (WALK_W'(j) < eff_valid);
         end
         if (in_run[j]) begin
            run_len = run_len + WALK_W'(1);
            mask    = mask | (PORT_W'(1) << eff_pin[j]);
         end
      end
   end

   assign result.hit         = consume;
   assign result.first_clear = start && first_pending;
   assign result.set_mask    = consume ? mask : '0;
   assign result.walk_next   = consume ? walk + run_len : walk;

endmodule

// ===== rtl/core/sorted_compare_led_pwm_core.sv =====
// sorted compare led pwm core: request register, update logic, response register
// a request is held in the request register and moves on to the response register once free
// throughput: one request per cycle while responses are taken; while a response
// waits the request register takes one more request, then the request side stalls
// reset: synchronous, clears counter, walk pointer, pins and both tables
// (levels unused), restores period_top and clear_mask to their defaults
module sorted_compare_led_pwm_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // op[1:0], slot[4:2], level[12:5], pin[17:13], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // port_mask[31:0], period_start[32], zero pad
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import scpwm_pkg::*;

   logic               s1_valid_ff, s1_valid_in;
   logic [1:0]         s1_op_ff;
   logic [SLOT_W-1:0]  s1_slot_ff;
   logic [LEVEL_W-1:0] s1_level_ff;
   logic [PIN_W-1:0]   s1_pin_ff;

   logic [LEVEL_W-1:0] period_top_ff;
   logic [PORT_W-1:0]  clear_mask_ff;
   logic [LEVEL_W-1:0] count_ff, count_in;
   logic [WALK_W-1:0]  walk_ff, walk_in;
   logic               first_ff, first_in;
   logic [PORT_W-1:0]  pins_ff, pins_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PORT_W-1:0]  rsp_mask_ff;
   logic               rsp_start_ff;

   logic               advance;
   logic               is_tick;
   logic               wrap;
   logic [WALK_W-1:0]  walk_eff;
   logic [PORT_W-1:0]  pins_base;
   level_arr_type      eff_level;
   pin_arr_type        eff_pin;
   logic [WALK_W-1:0]  eff_valid;
   match_type          match;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign is_tick    = advance && (s1_op_ff == OP_TICK);
   assign wrap       = is_tick && (count_ff >= period_top_ff);
   assign walk_eff   = wrap ? '0 : walk_ff;
   assign pins_base  = wrap ? (pins_ff & ~clear_mask_ff) : pins_ff;
   assign count_in   = is_tick ? (wrap ? '0 : count_ff + LEVEL_W'(1)) : count_ff;

   scpwm_table u_table (
      .clock       (clock),
      .reset       (reset),
      .write_en    (advance && (s1_op_ff == OP_WRITE) && ({1'b0, s1_slot_ff} < WALK_W'(SLOTS))),
      .write_slot  (s1_slot_ff),
      .write_level (s1_level_ff),
      .write_pin   (s1_pin_ff),
      .commit_req  (advance && (s1_op_ff == OP_COMMIT)),
      .wrap        (wrap),
      .eff_level   (eff_level),
      .eff_pin     (eff_pin),
      .eff_valid   (eff_valid)
   );

   scpwm_match u_match (
      .eff_level     (eff_level),
      .eff_pin       (eff_pin),
      .eff_valid     (eff_valid),
      .walk          (walk_eff),
      .count         (count_in),
      .first_pending (first_ff),
      .result        (match)
   );

   always_comb begin
      walk_in  = walk_ff;
      first_in = first_ff;
      pins_in  = pins_ff;
      if (is_tick) begin
         walk_in  = match.walk_next;
         first_in = first_ff && !match.first_clear;
         pins_in  = pins_base | match.set_mask;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         period_top_ff <= PERIOD_TOP_RESET;
         clear_mask_ff <= CLEAR_MASK_RESET;
         count_ff      <= '0;
         walk_ff       <= '0;
         first_ff      <= 1'b1;
         pins_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         first_ff     <= first_in;
         pins_ff      <= pins_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_PERIOD_TOP: period_top_ff <= csr_wdata[LEVEL_W-1:0];
               CSR_CLEAR_MASK: clear_mask_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_op_ff    <= req_tdata[1:0];
         s1_slot_ff  <= req_tdata[4:2];
         s1_level_ff <= req_tdata[12:5];
         s1_pin_ff   <= req_tdata[17:13];
      end
      if (advance) begin
         rsp_mask_ff  <= pins_in;
         rsp_start_ff <= wrap;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_start_ff, rsp_mask_ff};

endmodule
